@@ sv/rkc_pkg.sv @@
// ----------------------------------------------------------------------------
// rkc_pkg: shared types and constants of the keyed-table packet cipher
// Holds the beat structs, operation codes, controller states, the
// controller-to-datapath command struct and the Blowfish S-box table.
// ----------------------------------------------------------------------------
package rkc_pkg;

    localparam int unsigned KEY_MAX_BYTES = 256;
    localparam int unsigned ROM_WORDS     = 1024;

    typedef enum logic [1:0] {
        ACT_LOAD_KEY = 2'd0,
        ACT_SCHEDULE = 2'd1,
        ACT_CIPHER   = 2'd2,
        ACT_UNUSED   = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  key_index;
        logic [7:0]  key_byte;
        logic [31:0] packet_number;
        logic [13:0] word_index;
        logic [15:0] packet_bytes;
        logic [31:0] data_word;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] result_word;
        logic        was_ciphered;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_KSA,
        ST_PRGA,
        ST_CIPH
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_KEY_WR,
        OP_CIPH_RD,
        OP_CIPH_OUT,
        OP_INIT_WR,
        OP_KSA_A,
        OP_KSA_B,
        OP_KSA_C,
        OP_KSA_D,
        OP_PRGA_A,
        OP_PRGA_B,
        OP_PRGA_C,
        OP_PRGA_D,
        OP_PRGA_E,
        OP_PRGA_F
    } t_dp_op;

    typedef struct packed {
        t_dp_op      op;
        logic [11:0] cnt;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    // Standard Blowfish S-boxes, box 0 first.
    localparam logic [31:0] BF_ROM [ROM_WORDS] = '{
        32'hd1310ba6, 32'h98dfb5ac, 32'h2ffd72db, 32'hd01adfb7,
        32'hb8e1afed, 32'h6a267e96, 32'hba7c9045, 32'hf12c7f99,
        32'h24a19947, 32'hb3916cf7, 32'h0801f2e2, 32'h858efc16,
        32'h636920d8, 32'h71574e69, 32'ha458fea3, 32'hf4933d7e,
        32'h0d95748f, 32'h728eb658, 32'h718bcd58, 32'h82154aee,
        32'h7b54a41d, 32'hc25a59b5, 32'h9c30d539, 32'h2af26013,
        32'hc5d1b023, 32'h286085f0, 32'hca417918, 32'hb8db38ef,
        32'h8e79dcb0, 32'h603a180e, 32'h6c9e0e8b, 32'hb01e8a3e,
        32'hd71577c1, 32'hbd314b27, 32'h78af2fda, 32'h55605c60,
        32'he65525f3, 32'haa55ab94, 32'h57489862, 32'h63e81440,
        32'h55ca396a, 32'h2aab10b6, 32'hb4cc5c34, 32'h1141e8ce,
        32'ha15486af, 32'h7c72e993, 32'hb3ee1411, 32'h636fbc2a,
        32'h2ba9c55d, 32'h741831f6, 32'hce5c3e16, 32'h9b87931e,
        32'hafd6ba33, 32'h6c24cf5c, 32'h7a325381, 32'h28958677,
        32'h3b8f4898, 32'h6b4bb9af, 32'hc4bfe81b, 32'h66282193,
        32'h61d809cc, 32'hfb21a991, 32'h487cac60, 32'h5dec8032,
        32'hef845d5d, 32'he98575b1, 32'hdc262302, 32'heb651b88,
        32'h23893e81, 32'hd396acc5, 32'h0f6d6ff3, 32'h83f44239,
        32'h2e0b4482, 32'ha4842004, 32'h69c8f04a, 32'h9e1f9b5e,
        32'h21c66842, 32'hf6e96c9a, 32'h670c9c61, 32'habd388f0,
        32'h6a51a0d2, 32'hd8542f68, 32'h960fa728, 32'hab5133a3,
        32'h6eef0b6c, 32'h137a3be4, 32'hba3bf050, 32'h7efb2a98,
        32'ha1f1651d, 32'h39af0176, 32'h66ca593e, 32'h82430e88,
        32'h8cee8619, 32'h456f9fb4, 32'h7d84a5c3, 32'h3b8b5ebe,
        32'he06f75d8, 32'h85c12073, 32'h401a449f, 32'h56c16aa6,
        32'h4ed3aa62, 32'h363f7706, 32'h1bfedf72, 32'h429b023d,
        32'h37d0d724, 32'hd00a1248, 32'hdb0fead3, 32'h49f1c09b,
        32'h075372c9, 32'h80991b7b, 32'h25d479d8, 32'hf6e8def7,
        32'he3fe501a, 32'hb6794c3b, 32'h976ce0bd, 32'h04c006ba,
        32'hc1a94fb6, 32'h409f60c4, 32'h5e5c9ec2, 32'h196a2463,
        32'h68fb6faf, 32'h3e6c53b5, 32'h1339b2eb, 32'h3b52ec6f,
        32'h6dfc511f, 32'h9b30952c, 32'hcc814544, 32'haf5ebd09,
        32'hbee3d004, 32'hde334afd, 32'h660f2807, 32'h192e4bb3,
        32'hc0cba857, 32'h45c8740f, 32'hd20b5f39, 32'hb9d3fbdb,
        32'h5579c0bd, 32'h1a60320a, 32'hd6a100c6, 32'h402c7279,
        32'h679f25fe, 32'hfb1fa3cc, 32'h8ea5e9f8, 32'hdb3222f8,
        32'h3c7516df, 32'hfd616b15, 32'h2f501ec8, 32'had0552ab,
        32'h323db5fa, 32'hfd238760, 32'h53317b48, 32'h3e00df82,
        32'h9e5c57bb, 32'hca6f8ca0, 32'h1a87562e, 32'hdf1769db,
        32'hd542a8f6, 32'h287effc3, 32'hac6732c6, 32'h8c4f5573,
        32'h695b27b0, 32'hbbca58c8, 32'he1ffa35d, 32'hb8f011a0,
        32'h10fa3d98, 32'hfd2183b8, 32'h4afcb56c, 32'h2dd1d35b,
        32'h9a53e479, 32'hb6f84565, 32'hd28e49bc, 32'h4bfb9790,
        32'he1ddf2da, 32'ha4cb7e33, 32'h62fb1341, 32'hcee4c6e8,
        32'hef20cada, 32'h36774c01, 32'hd07e9efe, 32'h2bf11fb4,
        32'h95dbda4d, 32'hae909198, 32'heaad8e71, 32'h6b93d5a0,
        32'hd08ed1d0, 32'hafc725e0, 32'h8e3c5b2f, 32'h8e7594b7,
        32'h8ff6e2fb, 32'hf2122b64, 32'h8888b812, 32'h900df01c,
        32'h4fad5ea0, 32'h688fc31c, 32'hd1cff191, 32'hb3a8c1ad,
        32'h2f2f2218, 32'hbe0e1777, 32'hea752dfe, 32'h8b021fa1,
        32'he5a0cc0f, 32'hb56f74e8, 32'h18acf3d6, 32'hce89e299,
        32'hb4a84fe0, 32'hfd13e0b7, 32'h7cc43b81, 32'hd2ada8d9,
        32'h165fa266, 32'h80957705, 32'h93cc7314, 32'h211a1477,
        32'he6ad2065, 32'h77b5fa86, 32'hc75442f5, 32'hfb9d35cf,
        32'hebcdaf0c, 32'h7b3e89a0, 32'hd6411bd3, 32'hae1e7e49,
        32'h00250e2d, 32'h2071b35e, 32'h226800bb, 32'h57b8e0af,
        32'h2464369b, 32'hf009b91e, 32'h5563911d, 32'h59dfa6aa,
        32'h78c14389, 32'hd95a537f, 32'h207d5ba2, 32'h02e5b9c5,
        32'h83260376, 32'h6295cfa9, 32'h11c81968, 32'h4e734a41,
        32'hb3472dca, 32'h7b14a94a, 32'h1b510052, 32'h9a532915,
        32'hd60f573f, 32'hbc9bc6e4, 32'h2b60a476, 32'h81e67400,
        32'h08ba6fb5, 32'h571be91f, 32'hf296ec6b, 32'h2a0dd915,
        32'hb6636521, 32'he7b9f9b6, 32'hff34052e, 32'hc5855664,
        32'h53b02d5d, 32'ha99f8fa1, 32'h08ba4799, 32'h6e85076a,
        32'h4b7a70e9, 32'hb5b32944, 32'hdb75092e, 32'hc4192623,
        32'had6ea6b0, 32'h49a7df7d, 32'h9cee60b8, 32'h8fedb266,
        32'hecaa8c71, 32'h699a17ff, 32'h5664526c, 32'hc2b19ee1,
        32'h193602a5, 32'h75094c29, 32'ha0591340, 32'he4183a3e,
        32'h3f54989a, 32'h5b429d65, 32'h6b8fe4d6, 32'h99f73fd6,
        32'ha1d29c07, 32'hefe830f5, 32'h4d2d38e6, 32'hf0255dc1,
        32'h4cdd2086, 32'h8470eb26, 32'h6382e9c6, 32'h021ecc5e,
        32'h09686b3f, 32'h3ebaefc9, 32'h3c971814, 32'h6b6a70a1,
        32'h687f3584, 32'h52a0e286, 32'hb79c5305, 32'haa500737,
        32'h3e07841c, 32'h7fdeae5c, 32'h8e7d44ec, 32'h5716f2b8,
        32'hb03ada37, 32'hf0500c0d, 32'hf01c1f04, 32'h0200b3ff,
        32'hae0cf51a, 32'h3cb574b2, 32'h25837a58, 32'hdc0921bd,
        32'hd19113f9, 32'h7ca92ff6, 32'h94324773, 32'h22f54701,
        32'h3ae5e581, 32'h37c2dadc, 32'hc8b57634, 32'h9af3dda7,
        32'ha9446146, 32'h0fd0030e, 32'hecc8c73e, 32'ha4751e41,
        32'he238cd99, 32'h3bea0e2f, 32'h3280bba1, 32'h183eb331,
        32'h4e548b38, 32'h4f6db908, 32'h6f420d03, 32'hf60a04bf,
        32'h2cb81290, 32'h24977c79, 32'h5679b072, 32'hbcaf89af,
        32'hde9a771f, 32'hd9930810, 32'hb38bae12, 32'hdccf3f2e,
        32'h5512721f, 32'h2e6b7124, 32'h501adde6, 32'h9f84cd87,
        32'h7a584718, 32'h7408da17, 32'hbc9f9abc, 32'he94b7d8c,
        32'hec7aec3a, 32'hdb851dfa, 32'h63094366, 32'hc464c3d2,
        32'hef1c1847, 32'h3215d908, 32'hdd433b37, 32'h24c2ba16,
        32'h12a14d43, 32'h2a65c451, 32'h50940002, 32'h133ae4dd,
        32'h71dff89e, 32'h10314e55, 32'h81ac77d6, 32'h5f11199b,
        32'h043556f1, 32'hd7a3c76b, 32'h3c11183b, 32'h5924a509,
        32'hf28fe6ed, 32'h97f1fbfa, 32'h9ebabf2c, 32'h1e153c6e,
        32'h86e34570, 32'heae96fb1, 32'h860e5e0a, 32'h5a3e2ab3,
        32'h771fe71c, 32'h4e3d06fa, 32'h2965dcb9, 32'h99e71d0f,
        32'h803e89d6, 32'h5266c825, 32'h2e4cc978, 32'h9c10b36a,
        32'hc6150eba, 32'h94e2ea78, 32'ha5fc3c53, 32'h1e0a2df4,
        32'hf2f74ea7, 32'h361d2b3d, 32'h1939260f, 32'h19c27960,
        32'h5223a708, 32'hf71312b6, 32'hebadfe6e, 32'heac31f66,
        32'he3bc4595, 32'ha67bc883, 32'hb17f37d1, 32'h018cff28,
        32'hc332ddef, 32'hbe6c5aa5, 32'h65582185, 32'h68ab9802,
        32'heecea50f, 32'hdb2f953b, 32'h2aef7dad, 32'h5b6e2f84,
        32'h1521b628, 32'h29076170, 32'hecdd4775, 32'h619f1510,
        32'h13cca830, 32'heb61bd96, 32'h0334fe1e, 32'haa0363cf,
        32'hb5735c90, 32'h4c70a239, 32'hd59e9e0b, 32'hcbaade14,
        32'heecc86bc, 32'h60622ca7, 32'h9cab5cab, 32'hb2f3846e,
        32'h648b1eaf, 32'h19bdf0ca, 32'ha02369b9, 32'h655abb50,
        32'h40685a32, 32'h3c2ab4b3, 32'h319ee9d5, 32'hc021b8f7,
        32'h9b540b19, 32'h875fa099, 32'h95f7997e, 32'h623d7da8,
        32'hf837889a, 32'h97e32d77, 32'h11ed935f, 32'h16681281,
        32'h0e358829, 32'hc7e61fd6, 32'h96dedfa1, 32'h7858ba99,
        32'h57f584a5, 32'h1b227263, 32'h9b83c3ff, 32'h1ac24696,
        32'hcdb30aeb, 32'h532e3054, 32'h8fd948e4, 32'h6dbc3128,
        32'h58ebf2ef, 32'h34c6ffea, 32'hfe28ed61, 32'hee7c3c73,
        32'h5d4a14d9, 32'he864b7e3, 32'h42105d14, 32'h203e13e0,
        32'h45eee2b6, 32'ha3aaabea, 32'hdb6c4f15, 32'hfacb4fd0,
        32'hc742f442, 32'hef6abbb5, 32'h654f3b1d, 32'h41cd2105,
        32'hd81e799e, 32'h86854dc7, 32'he44b476a, 32'h3d816250,
        32'hcf62a1f2, 32'h5b8d2646, 32'hfc8883a0, 32'hc1c7b6a3,
        32'h7f1524c3, 32'h69cb7492, 32'h47848a0b, 32'h5692b285,
        32'h095bbf00, 32'had19489d, 32'h1462b174, 32'h23820e00,
        32'h58428d2a, 32'h0c55f5ea, 32'h1dadf43e, 32'h233f7061,
        32'h3372f092, 32'h8d937e41, 32'hd65fecf1, 32'h6c223bdb,
        32'h7cde3759, 32'hcbee7460, 32'h4085f2a7, 32'hce77326e,
        32'ha6078084, 32'h19f8509e, 32'he8efd855, 32'h61d99735,
        32'ha969a7aa, 32'hc50c06c2, 32'h5a04abfc, 32'h800bcadc,
        32'h9e447a2e, 32'hc3453484, 32'hfdd56705, 32'h0e1e9ec9,
        32'hdb73dbd3, 32'h105588cd, 32'h675fda79, 32'he3674340,
        32'hc5c43465, 32'h713e38d8, 32'h3d28f89e, 32'hf16dff20,
        32'h153e21e7, 32'h8fb03d4a, 32'he6e39f2b, 32'hdb83adf7,
        32'he93d5a68, 32'h948140f7, 32'hf64c261c, 32'h94692934,
        32'h411520f7, 32'h7602d4f7, 32'hbcf46b2e, 32'hd4a20068,
        32'hd4082471, 32'h3320f46a, 32'h43b7d4b7, 32'h500061af,
        32'h1e39f62e, 32'h97244546, 32'h14214f74, 32'hbf8b8840,
        32'h4d95fc1d, 32'h96b591af, 32'h70f4ddd3, 32'h66a02f45,
        32'hbfbc09ec, 32'h03bd9785, 32'h7fac6dd0, 32'h31cb8504,
        32'h96eb27b3, 32'h55fd3941, 32'hda2547e6, 32'habca0a9a,
        32'h28507825, 32'h530429f4, 32'h0a2c86da, 32'he9b66dfb,
        32'h68dc1462, 32'hd7486900, 32'h680ec0a4, 32'h27a18dee,
        32'h4f3ffea2, 32'he887ad8c, 32'hb58ce006, 32'h7af4d6b6,
        32'haace1e7c, 32'hd3375fec, 32'hce78a399, 32'h406b2a42,
        32'h20fe9e35, 32'hd9f385b9, 32'hee39d7ab, 32'h3b124e8b,
        32'h1dc9faf7, 32'h4b6d1856, 32'h26a36631, 32'heae397b2,
        32'h3a6efa74, 32'hdd5b4332, 32'h6841e7f7, 32'hca7820fb,
        32'hfb0af54e, 32'hd8feb397, 32'h454056ac, 32'hba489527,
        32'h55533a3a, 32'h20838d87, 32'hfe6ba9b7, 32'hd096954b,
        32'h55a867bc, 32'ha1159a58, 32'hcca92963, 32'h99e1db33,
        32'ha62a4a56, 32'h3f3125f9, 32'h5ef47e1c, 32'h9029317c,
        32'hfdf8e802, 32'h04272f70, 32'h80bb155c, 32'h05282ce3,
        32'h95c11548, 32'he4c66d22, 32'h48c1133f, 32'hc70f86dc,
        32'h07f9c9ee, 32'h41041f0f, 32'h404779a4, 32'h5d886e17,
        32'h325f51eb, 32'hd59bc0d1, 32'hf2bcc18f, 32'h41113564,
        32'h257b7834, 32'h602a9c60, 32'hdff8e8a3, 32'h1f636c1b,
        32'h0e12b4c2, 32'h02e1329e, 32'haf664fd1, 32'hcad18115,
        32'h6b2395e0, 32'h333e92e1, 32'h3b240b62, 32'heebeb922,
        32'h85b2a20e, 32'he6ba0d99, 32'hde720c8c, 32'h2da2f728,
        32'hd0127845, 32'h95b794fd, 32'h647d0862, 32'he7ccf5f0,
        32'h5449a36f, 32'h877d48fa, 32'hc39dfd27, 32'hf33e8d1e,
        32'h0a476341, 32'h992eff74, 32'h3a6f6eab, 32'hf4f8fd37,
        32'ha812dc60, 32'ha1ebddf8, 32'h991be14c, 32'hdb6e6b0d,
        32'hc67b5510, 32'h6d672c37, 32'h2765d43b, 32'hdcd0e804,
        32'hf1290dc7, 32'hcc00ffa3, 32'hb5390f92, 32'h690fed0b,
        32'h667b9ffb, 32'hcedb7d9c, 32'ha091cf0b, 32'hd9155ea3,
        32'hbb132f88, 32'h515bad24, 32'h7b9479bf, 32'h763bd6eb,
        32'h37392eb3, 32'hcc115979, 32'h8026e297, 32'hf42e312d,
        32'h6842ada7, 32'hc66a2b3b, 32'h12754ccc, 32'h782ef11c,
        32'h6a124237, 32'hb79251e7, 32'h06a1bbe6, 32'h4bfb6350,
        32'h1a6b1018, 32'h11caedfa, 32'h3d25bdd8, 32'he2e1c3c9,
        32'h44421659, 32'h0a121386, 32'hd90cec6e, 32'hd5abea2a,
        32'h64af674e, 32'hda86a85f, 32'hbebfe988, 32'h64e4c3fe,
        32'h9dbc8057, 32'hf0f7c086, 32'h60787bf8, 32'h6003604d,
        32'hd1fd8346, 32'hf6381fb0, 32'h7745ae04, 32'hd736fccc,
        32'h83426b33, 32'hf01eab71, 32'hb0804187, 32'h3c005e5f,
        32'h77a057be, 32'hbde8ae24, 32'h55464299, 32'hbf582e61,
        32'h4e58f48f, 32'hf2ddfda2, 32'hf474ef38, 32'h8789bdc2,
        32'h5366f9c3, 32'hc8b38e74, 32'hb475f255, 32'h46fcd9b9,
        32'h7aeb2661, 32'h8b1ddf84, 32'h846a0e79, 32'h915f95e2,
        32'h466e598e, 32'h20b45770, 32'h8cd55591, 32'hc902de4c,
        32'hb90bace1, 32'hbb8205d0, 32'h11a86248, 32'h7574a99e,
        32'hb77f19b6, 32'he0a9dc09, 32'h662d09a1, 32'hc4324633,
        32'he85a1f02, 32'h09f0be8c, 32'h4a99a025, 32'h1d6efe10,
        32'h1ab93d1d, 32'h0ba5a4df, 32'ha186f20f, 32'h2868f169,
        32'hdcb7da83, 32'h573906fe, 32'ha1e2ce9b, 32'h4fcd7f52,
        32'h50115e01, 32'ha70683fa, 32'ha002b5c4, 32'h0de6d027,
        32'h9af88c27, 32'h773f8641, 32'hc3604c06, 32'h61a806b5,
        32'hf0177a28, 32'hc0f586e0, 32'h006058aa, 32'h30dc7d62,
        32'h11e69ed7, 32'h2338ea63, 32'h53c2dd94, 32'hc2c21634,
        32'hbbcbee56, 32'h90bcb6de, 32'hebfc7da1, 32'hce591d76,
        32'h6f05e409, 32'h4b7c0188, 32'h39720a3d, 32'h7c927c24,
        32'h86e3725f, 32'h724d9db9, 32'h1ac15bb4, 32'hd39eb8fc,
        32'hed545578, 32'h08fca5b5, 32'hd83d7cd3, 32'h4dad0fc4,
        32'h1e50ef5e, 32'hb161e6f8, 32'ha28514d9, 32'h6c51133c,
        32'h6fd5c7e7, 32'h56e14ec4, 32'h362abfce, 32'hddc6c837,
        32'hd79a3234, 32'h92638212, 32'h670efa8e, 32'h406000e0,
        32'h3a39ce37, 32'hd3faf5cf, 32'habc27737, 32'h5ac52d1b,
        32'h5cb0679e, 32'h4fa33742, 32'hd3822740, 32'h99bc9bbe,
        32'hd5118e9d, 32'hbf0f7315, 32'hd62d1c7e, 32'hc700c47b,
        32'hb78c1b6b, 32'h21a19045, 32'hb26eb1be, 32'h6a366eb4,
        32'h5748ab2f, 32'hbc946e79, 32'hc6a376d2, 32'h6549c2c8,
        32'h530ff8ee, 32'h468dde7d, 32'hd5730a1d, 32'h4cd04dc6,
        32'h2939bbdb, 32'ha9ba4650, 32'hac9526e8, 32'hbe5ee304,
        32'ha1fad5f0, 32'h6a2d519a, 32'h63ef8ce2, 32'h9a86ee22,
        32'hc089c2b8, 32'h43242ef6, 32'ha51e03aa, 32'h9cf2d0a4,
        32'h83c061ba, 32'h9be96a4d, 32'h8fe51550, 32'hba645bd6,
        32'h2826a2f9, 32'ha73a3ae1, 32'h4ba99586, 32'hef5562e9,
        32'hc72fefd3, 32'hf752f7da, 32'h3f046f69, 32'h77fa0a59,
        32'h80e4a915, 32'h87b08601, 32'h9b09e6ad, 32'h3b3ee593,
        32'he990fd5a, 32'h9e34d797, 32'h2cf0b7d9, 32'h022b8b51,
        32'h96d5ac3a, 32'h017da67d, 32'hd1cf3ed6, 32'h7c7d2d28,
        32'h1f9f25cf, 32'hadf2b89b, 32'h5ad6b472, 32'h5a88f54c,
        32'he029ac71, 32'he019a5e6, 32'h47b0acfd, 32'hed93fa9b,
        32'he8d3c48d, 32'h283b57cc, 32'hf8d56629, 32'h79132e28,
        32'h785f0191, 32'hed756055, 32'hf7960e44, 32'he3d35e8c,
        32'h15056dd4, 32'h88f46dba, 32'h03a16125, 32'h0564f0bd,
        32'hc3eb9e15, 32'h3c9057a2, 32'h97271aec, 32'ha93a072a,
        32'h1b3f6d9b, 32'h1e6321f5, 32'hf59c66fb, 32'h26dcf319,
        32'h7533d928, 32'hb155fdf5, 32'h03563482, 32'h8aba3cbb,
        32'h28517711, 32'hc20ad9f8, 32'habcc5167, 32'hccad925f,
        32'h4de81751, 32'h3830dc8e, 32'h379d5862, 32'h9320f991,
        32'hea7a90c2, 32'hfb3e7bce, 32'h5121ce64, 32'h774fbe32,
        32'ha8b6e37e, 32'hc3293d46, 32'h48de5369, 32'h6413e680,
        32'ha2ae0810, 32'hdd6db224, 32'h69852dfd, 32'h09072166,
        32'hb39a460a, 32'h6445c0dd, 32'h586cdecf, 32'h1c20c8ae,
        32'h5bbef7dd, 32'h1b588d40, 32'hccd2017f, 32'h6bb4e3bb,
        32'hdda26a7e, 32'h3a59ff45, 32'h3e350a44, 32'hbcb4cdd5,
        32'h72eacea8, 32'hfa6484bb, 32'h8d6612ae, 32'hbf3c6f47,
        32'hd29be463, 32'h542f5d9e, 32'haec2771b, 32'hf64e6370,
        32'h740e0d8d, 32'he75b1357, 32'hf8721671, 32'haf537d5d,
        32'h4040cb08, 32'h4eb4e2cc, 32'h34d2466a, 32'h0115af84,
        32'he1b00428, 32'h95983a1d, 32'h06b89fb4, 32'hce6ea048,
        32'h6f3f3b82, 32'h3520ab82, 32'h011a1d4b, 32'h277227f8,
        32'h611560b1, 32'he7933fdc, 32'hbb3a792b, 32'h344525bd,
        32'ha08839e1, 32'h51ce794b, 32'h2f32c9b7, 32'ha01fbac9,
        32'he01cc87e, 32'hbcc7d1f6, 32'hcf0111c3, 32'ha1e8aac7,
        32'h1a908749, 32'hd44fbd9a, 32'hd0dadecb, 32'hd50ada38,
        32'h0339c32a, 32'hc6913667, 32'h8df9317c, 32'he0b12b4f,
        32'hf79e59b7, 32'h43f5bb3a, 32'hf2d519ff, 32'h27d9459c,
        32'hbf97222c, 32'h15e6fc2a, 32'h0f91fc71, 32'h9b941525,
        32'hfae59361, 32'hceb69ceb, 32'hc2a86459, 32'h12baa8d1,
        32'hb6c1075e, 32'he3056a0c, 32'h10d25065, 32'hcb03a442,
        32'he0ec6e0e, 32'h1698db3b, 32'h4c98a0be, 32'h3278e964,
        32'h9f1f9532, 32'he0d392df, 32'hd3a0342b, 32'h8971f21e,
        32'h1b0a7441, 32'h4ba3348c, 32'hc5be7120, 32'hc37632d8,
        32'hdf359f8d, 32'h9b992f2e, 32'he60b6f47, 32'h0fe3f11d,
        32'he54cda54, 32'h1edad891, 32'hce6279cf, 32'hcd3e7e6f,
        32'h1618b166, 32'hfd2c1d05, 32'h848fd2c5, 32'hf6fb2299,
        32'hf523f357, 32'ha6327623, 32'h93a83531, 32'h56cccd02,
        32'hacf08162, 32'h5a75ebb5, 32'h6e163697, 32'h88d273cc,
        32'hde966292, 32'h81b949d0, 32'h4c50901b, 32'h71c65614,
        32'he6c6c7bd, 32'h327a140a, 32'h45e1d006, 32'hc3f27b9a,
        32'hc9aa53fd, 32'h62a80f00, 32'hbb25bfe2, 32'h35bdd2f6,
        32'h71126905, 32'hb2040222, 32'hb6cbcf7c, 32'hcd769c2b,
        32'h53113ec0, 32'h1640e3d3, 32'h38abbd60, 32'h2547adf0,
        32'hba38209c, 32'hf746ce76, 32'h77afa1c5, 32'h20756060,
        32'h85cbfe4e, 32'h8ae88dd8, 32'h7aaaf9b0, 32'h4cf9aa7e,
        32'h1948c25c, 32'h02fb8a8c, 32'h01c36ae4, 32'hd6ebe1f9,
        32'h90d4f869, 32'ha65cdea0, 32'h3f09252d, 32'hc208e69f,
        32'hb74e6132, 32'hce77e25b, 32'h578fdfe3, 32'h3ac372e6
    };

endpackage

@@ sv/rkc_ctrl.sv @@
// ----------------------------------------------------------------------------
// rkc_ctrl: sequencing state machine of the keyed-table packet cipher
// Decodes load-key and cipher beats, walks the permutation init, key schedule
// and table generation phases, and issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module rkc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_action,
    input  rkc_pkg::t_dp_status i_status,
    output logic                o_in_stall,
    output rkc_pkg::t_dp_cmd    o_cmd
);

    rkc_pkg::t_state r_state, n_state;
    logic [11:0]     r_cnt, n_cnt;
    logic [2:0]      r_ph, n_ph;
    logic            w_accept;

    assign w_accept = i_in_valid && (r_state == rkc_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rkc_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_ph    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ph    <= n_ph;
        end
    end

    // Next state and step counters.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ph    = r_ph;
        case (r_state)
            rkc_pkg::ST_IDLE: begin
                n_cnt = '0;
                n_ph  = '0;
                if (w_accept && (i_action == rkc_pkg::ACT_SCHEDULE)) begin
                    n_state = rkc_pkg::ST_INIT;
                end else if (w_accept && (i_action == rkc_pkg::ACT_CIPHER)) begin
                    n_state = rkc_pkg::ST_CIPH;
                end
            end
            rkc_pkg::ST_INIT: begin
                if (r_cnt[7:0] == 8'hff) begin
                    n_state = rkc_pkg::ST_KSA;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 12'd1;
                end
            end
            rkc_pkg::ST_KSA: begin
                if (r_ph == 3'd3) begin
                    n_ph = '0;
                    if (r_cnt[7:0] == 8'hff) begin
                        n_state = rkc_pkg::ST_PRGA;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + 12'd1;
                    end
                end else begin
                    n_ph = r_ph + 3'd1;
                end
            end
            rkc_pkg::ST_PRGA: begin
                if (r_ph == 3'd5) begin
                    n_ph = '0;
                    if (r_cnt == 12'hfff) begin
                        n_state = rkc_pkg::ST_IDLE;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + 12'd1;
                    end
                end else begin
                    n_ph = r_ph + 3'd1;
                end
            end
            rkc_pkg::ST_CIPH: begin
                if (i_status.out_free) begin
                    n_state = rkc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rkc_pkg::ST_IDLE;
            end
        endcase
    end

    // Command decode.
    always_comb begin
        o_cmd.cnt = r_cnt;
        o_cmd.op  = rkc_pkg::OP_NONE;
        case (r_state)
            rkc_pkg::ST_IDLE: begin
                if (w_accept && (i_action == rkc_pkg::ACT_LOAD_KEY)) begin
                    o_cmd.op = rkc_pkg::OP_KEY_WR;
                end else if (w_accept && (i_action == rkc_pkg::ACT_CIPHER)) begin
                    o_cmd.op = rkc_pkg::OP_CIPH_RD;
                end
            end
            rkc_pkg::ST_INIT: o_cmd.op = rkc_pkg::OP_INIT_WR;
            rkc_pkg::ST_KSA: begin
                case (r_ph)
                    3'd0:    o_cmd.op = rkc_pkg::OP_KSA_A;
                    3'd1:    o_cmd.op = rkc_pkg::OP_KSA_B;
                    3'd2:    o_cmd.op = rkc_pkg::OP_KSA_C;
                    default: o_cmd.op = rkc_pkg::OP_KSA_D;
                endcase
            end
            rkc_pkg::ST_PRGA: begin
                case (r_ph)
                    3'd0:    o_cmd.op = rkc_pkg::OP_PRGA_A;
                    3'd1:    o_cmd.op = rkc_pkg::OP_PRGA_B;
                    3'd2:    o_cmd.op = rkc_pkg::OP_PRGA_C;
                    3'd3:    o_cmd.op = rkc_pkg::OP_PRGA_D;
                    3'd4:    o_cmd.op = rkc_pkg::OP_PRGA_E;
                    default: o_cmd.op = rkc_pkg::OP_PRGA_F;
                endcase
            end
            rkc_pkg::ST_CIPH: begin
                if (i_status.out_free) begin
                    o_cmd.op = rkc_pkg::OP_CIPH_OUT;
                end
            end
            default: o_cmd.op = rkc_pkg::OP_NONE;
        endcase
    end

    assign o_in_stall = (r_state != rkc_pkg::ST_IDLE);

`ifndef SYNTHESIS
    a_ksa_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rkc_pkg::ST_KSA) |-> (r_cnt[11:8] == 4'd0))
        else $error("key schedule counter out of range");
    a_init_to_ksa: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rkc_pkg::ST_INIT && r_cnt == 12'd255) |=>
        (r_state == rkc_pkg::ST_KSA && r_cnt == 12'd0 && r_ph == 3'd0))
        else $error("init did not hand over to key schedule");
    a_prga_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rkc_pkg::ST_PRGA && r_ph == 3'd5 && r_cnt == 12'hfff) |=>
        (r_state == rkc_pkg::ST_IDLE))
        else $error("table generation did not finish");
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph <= 3'd5))
        else $error("phase counter out of range");
`endif

endmodule

@@ sv/rkc_dp.sv @@
// ----------------------------------------------------------------------------
// rkc_dp: datapath of the keyed-table packet cipher
// Key store, permutation and keyed table memories, the S-box ROM read,
// the RC4 index registers and the output register.
// ----------------------------------------------------------------------------
module rkc_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rkc_pkg::t_dp_cmd    i_cmd,
    input  rkc_pkg::t_in_beat   i_in,
    input  logic                i_cfg_valid,
    input  logic [8:0]          i_cfg_data,
    input  logic                i_out_stall,
    output rkc_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    output rkc_pkg::t_out_beat  o_out
);

    logic [7:0]  key_mem  [rkc_pkg::KEY_MAX_BYTES];
    logic [7:0]  perm_mem [256];
    logic [31:0] tab_mem  [rkc_pkg::ROM_WORDS];

    logic [8:0]  r_klen;
    logic [7:0]  r_kidx, r_j, r_si, r_x, r_y, r_a, r_b;
    logic [7:0]  r_perm_q, r_key_q;
    logic [31:0] r_rom_q, r_tab_q, r_data;
    logic [23:0] r_acc;
    logic        r_hit;
    logic        r_out_valid;
    rkc_pkg::t_out_beat r_out;

    logic [8:0]  w_klen;
    logic [7:0]  w_perm_raddr, w_perm_waddr, w_perm_wdata, w_j, w_ks_byte;
    logic        w_perm_we;
    logic [13:0] w_full;
    logic        w_hit;
    logic [9:0]  w_tab_raddr;

    // Key length: zero means one, anything above the store saturates.
    always_comb begin
        if (r_klen == 9'd0) begin
            w_klen = 9'd1;
        end else if (r_klen > 9'(rkc_pkg::KEY_MAX_BYTES)) begin
            w_klen = 9'(rkc_pkg::KEY_MAX_BYTES);
        end else begin
            w_klen = r_klen;
        end
    end

    assign w_j         = r_j + r_perm_q + r_key_q;
    assign w_ks_byte   = r_rom_q[{i_cmd.cnt[1:0], 3'b000} +: 8] ^ r_perm_q;
    assign w_full      = i_in.packet_bytes[15:2];
    assign w_hit       = (|i_in.packet_bytes[1:0])
                       ? ({1'b0, i_in.word_index} + 15'd1 < {1'b0, w_full})
                       : (i_in.word_index < w_full);
    assign w_tab_raddr = {i_in.packet_number[1:0], i_in.word_index[7:0]};

    // Permutation port selection.
    always_comb begin
        w_perm_raddr = i_cmd.cnt[7:0];
        w_perm_we    = 1'b0;
        w_perm_waddr = i_cmd.cnt[7:0];
        w_perm_wdata = i_cmd.cnt[7:0];
        case (i_cmd.op)
            rkc_pkg::OP_INIT_WR: w_perm_we = 1'b1;
            rkc_pkg::OP_KSA_B:   w_perm_raddr = w_j;
            rkc_pkg::OP_KSA_C: begin
                w_perm_we    = 1'b1;
                w_perm_wdata = r_perm_q;
            end
            rkc_pkg::OP_KSA_D: begin
                w_perm_we    = 1'b1;
                w_perm_waddr = r_j;
                w_perm_wdata = r_si;
            end
            rkc_pkg::OP_PRGA_A:  w_perm_raddr = r_x + 8'd1;
            rkc_pkg::OP_PRGA_B:  w_perm_raddr = r_y + r_perm_q;
            rkc_pkg::OP_PRGA_C: begin
                w_perm_we    = 1'b1;
                w_perm_waddr = r_x;
                w_perm_wdata = r_perm_q;
            end
            rkc_pkg::OP_PRGA_D: begin
                w_perm_we    = 1'b1;
                w_perm_waddr = r_y;
                w_perm_wdata = r_a;
            end
            rkc_pkg::OP_PRGA_E:  w_perm_raddr = r_a + r_b;
            default:             w_perm_raddr = i_cmd.cnt[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_perm_we) begin
            perm_mem[w_perm_waddr] <= w_perm_wdata;
        end
        r_perm_q <= perm_mem[w_perm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == rkc_pkg::OP_KEY_WR) begin
            key_mem[i_in.key_index] <= i_in.key_byte;
        end
        r_key_q <= key_mem[r_kidx];
    end

    always_ff @(posedge i_clk) begin
        r_rom_q <= rkc_pkg::BF_ROM[i_cmd.cnt[11:2]];
    end

    // The table word is captured with the accepted cipher beat and held
    // while the result waits for room in the output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == rkc_pkg::OP_PRGA_F && i_cmd.cnt[1:0] == 2'd3) begin
            tab_mem[i_cmd.cnt[11:2]] <= {w_ks_byte, r_acc};
        end
        if (i_cmd.op == rkc_pkg::OP_CIPH_RD) begin
            r_tab_q <= tab_mem[w_tab_raddr];
        end
    end

    // Schedule registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            rkc_pkg::OP_INIT_WR: begin
                r_j    <= '0;
                r_kidx <= '0;
                r_x    <= '0;
                r_y    <= '0;
            end
            rkc_pkg::OP_KSA_B: begin
                r_j  <= w_j;
                r_si <= r_perm_q;
                if ({1'b0, r_kidx} + 9'd1 == w_klen) begin
                    r_kidx <= '0;
                end else begin
                    r_kidx <= r_kidx + 8'd1;
                end
            end
            rkc_pkg::OP_PRGA_A: r_x <= r_x + 8'd1;
            rkc_pkg::OP_PRGA_B: begin
                r_a <= r_perm_q;
                r_y <= r_y + r_perm_q;
            end
            rkc_pkg::OP_PRGA_C: r_b <= r_perm_q;
            rkc_pkg::OP_PRGA_F: begin
                case (i_cmd.cnt[1:0])
                    2'd0:    r_acc[7:0]   <= w_ks_byte;
                    2'd1:    r_acc[15:8]  <= w_ks_byte;
                    2'd2:    r_acc[23:16] <= w_ks_byte;
                    default: r_acc        <= r_acc;
                endcase
            end
            rkc_pkg::OP_CIPH_RD: begin
                r_data <= i_in.data_word;
                r_hit  <= w_hit;
            end
            default: r_j <= r_j;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_klen <= 9'd1;
        end else if (i_cfg_valid) begin
            r_klen <= i_cfg_data;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == rkc_pkg::OP_CIPH_OUT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == rkc_pkg::OP_CIPH_OUT) begin
            r_out.result_word  <= r_data ^ (r_hit ? r_tab_q : 32'd0);
            r_out.was_ciphered <= r_hit;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;

`ifndef SYNTHESIS
    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == rkc_pkg::OP_CIPH_OUT) |-> o_status.out_free)
        else $error("result loaded over a waiting beat");
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == rkc_pkg::OP_CIPH_OUT) |=> r_out_valid)
        else $error("loaded result not presented");
    a_kidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == rkc_pkg::OP_KSA_B) |-> ({1'b0, r_kidx} < w_klen))
        else $error("key index beyond key length");
`endif

endmodule

@@ sv/rc4_keyed_table_packet_cipher_unit.sv @@
// ----------------------------------------------------------------------------
// rc4_keyed_table_packet_cipher_unit: RC4-keyed Blowfish table packet cipher
// Loads key bytes, builds four keyed 1 KiB tables from the Blowfish S-boxes
// XORed with RC4 keystream, and XORs in-range packet words with table words.
//
// Channel  Dir  Handshake          Beat
// in       in   valid / stall      action, key and packet fields
// out      out  valid / stall      result_word, was_ciphered
// cfg      in   valid / ready      key_length (9 bits)
//
// A load-key beat writes the key store directly. A cipher beat first reads
// the keyed table memory and then, once the output register has room, moves
// the word into it. A schedule beat stalls the input through the permutation
// init, key schedule and keystream steps, each of which makes one read or
// one write of the permutation memory.
// Reset is synchronous and active low; it clears the controller and the
// output valid, sets key_length to one, and leaves the memories unset.
// The output register lets the next beat enter while a result waits on a
// stall; a second cipher beat then holds until the output drains.
// ----------------------------------------------------------------------------
module rc4_keyed_table_packet_cipher_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rkc_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rkc_pkg::t_out_beat o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [8:0]         i_cfg_data
);

    rkc_pkg::t_dp_cmd    w_cmd;
    rkc_pkg::t_dp_status w_status;

    // Configuration is always taken; the user must change it only while idle, as the block does not enforce it.
    assign o_cfg_ready = 1'b1;

    rkc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_data.action),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    rkc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in        (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out       (o_out_data)
    );

endmodule

@@ verif/rc4_keyed_table_packet_cipher_unit_checker.sv @@
// ----------------------------------------------------------------------------
// rc4_keyed_table_packet_cipher_unit_checker: scoreboard of the packet cipher
// Watches the input, output and key-length channels, keeps its own copy of
// the key store and keyed tables, predicts every cipher result and compares.
// ----------------------------------------------------------------------------
module rc4_keyed_table_packet_cipher_unit_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  rkc_pkg::t_in_beat  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  rkc_pkg::t_out_beat i_out_data,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [8:0]         i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  key_bytes [rkc_pkg::KEY_MAX_BYTES];
    logic [7:0]  keyed_bytes [4096];
    logic [8:0]  key_len_reg;
    rkc_pkg::t_out_beat cipher_queue [$];

    initial o_fail_count = 0;
    assign o_pending = cipher_queue.size();

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    // Key schedule followed by keystream-masked copy of the S-box words.
    task automatic build_keyed_tables();
        logic [7:0] perm [256];
        logic [7:0] j, x, y, a, b, rom_byte;
        int klen;
        klen = (key_len_reg == 0) ? 1
             : (key_len_reg > rkc_pkg::KEY_MAX_BYTES) ? rkc_pkg::KEY_MAX_BYTES
                                                       : int'(key_len_reg);
        for (int i = 0; i < 256; i++) perm[i] = i[7:0];
        j = 8'd0;
        for (int i = 0; i < 256; i++) begin
            j = j + perm[i] + key_bytes[i % klen];
            a = perm[i]; perm[i] = perm[j]; perm[j] = a;
        end
        x = 8'd0; y = 8'd0;
        for (int i = 0; i < 4096; i++) begin
            x = x + 8'd1;
            a = perm[x];
            y = y + a;
            b = perm[y];
            perm[x] = b; perm[y] = a;
            rom_byte = 8'(rkc_pkg::BF_ROM[i >> 2] >> (8 * (i & 3)));
            keyed_bytes[i] = rom_byte ^ perm[8'(a + b)];
        end
    endtask

    function automatic rkc_pkg::t_out_beat cipher_word(input rkc_pkg::t_in_beat beat);
        rkc_pkg::t_out_beat r;
        logic [15:0] full;
        logic hit;
        int base;
        logic [31:0] mask;
        full = beat.packet_bytes >> 2;
        hit = (beat.packet_bytes[1:0] != 0) ? (32'(beat.word_index) + 1 < 32'(full))
                                             : (32'(beat.word_index) < 32'(full));
        mask = 32'd0;
        if (hit) begin
            base = (int'(beat.packet_number[1:0]) * 256 + int'(beat.word_index[7:0])) * 4;
            mask = {keyed_bytes[base+3], keyed_bytes[base+2], keyed_bytes[base+1],
                    keyed_bytes[base]};
        end
        r.result_word = beat.data_word ^ mask;
        r.was_ciphered = hit;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_len_reg <= 9'd1;
        end else begin
            if (i_cfg_valid && i_cfg_ready) key_len_reg <= i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                case (rkc_pkg::t_action'(i_in_data.action))
                    rkc_pkg::ACT_LOAD_KEY:
                        key_bytes[i_in_data.key_index] = i_in_data.key_byte;
                    rkc_pkg::ACT_SCHEDULE: build_keyed_tables();
                    rkc_pkg::ACT_CIPHER:   cipher_queue.push_back(cipher_word(i_in_data));
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (cipher_queue.size() == 0) begin
                    report_mismatch("unexpected result", i_out_data.result_word, 32'd0);
                end else begin
                    rkc_pkg::t_out_beat want;
                    want = cipher_queue.pop_front();
                    if (i_out_data.result_word !== want.result_word)
                        report_mismatch("result_word", i_out_data.result_word,
                                        want.result_word);
                    if (i_out_data.was_ciphered !== want.was_ciphered)
                        report_mismatch("was_ciphered", 32'(i_out_data.was_ciphered),
                                        32'(want.was_ciphered));
                end
            end
        end
    end
endmodule

@@ verif/rc4_keyed_table_packet_cipher_unit_test.sv @@
// ----------------------------------------------------------------------------
// rc4_keyed_table_packet_cipher_unit_test: testbench of the packet cipher
// Loads keys of several lengths, runs the key schedule, then streams cipher
// beats with random gaps and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module rc4_keyed_table_packet_cipher_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_BEATS = 170;

    logic      clk, rst_n;
    logic      in_valid, in_stall;
    rkc_pkg::t_in_beat  in_data;
    logic      out_valid, out_stall;
    rkc_pkg::t_out_beat out_data;
    logic      cfg_valid, cfg_ready;
    logic [8:0] cfg_data;
    int        fail_count, pending;
    int        cycle_count;

    // Idle percentages for the sender and the receiver; set per phase.
    int        send_idle_pct, recv_stall_pct;
    // Long receiver hold-off, counted down in the stall process.
    int        hold_cycles;

    rc4_keyed_table_packet_cipher_unit i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    rc4_keyed_table_packet_cipher_unit_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // The receiver stalls at random, or solidly through a requested hold-off.
    initial begin
        out_stall = 0;
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                out_stall <= 1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // The timeout watchdog.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("rc4_keyed_table_packet_cipher_unit_test: FAIL");
                $finish;
            end
        end
    end

    // Offer one beat, with a random idle gap first, and hold it until accepted.
    // Valid stays high on return; the next beat or wait_idle takes it down.
    task automatic send_beat(input rkc_pkg::t_in_beat beat);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    function automatic rkc_pkg::t_in_beat random_beat(input rkc_pkg::t_action act);
        rkc_pkg::t_in_beat b;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        b = raw[$bits(rkc_pkg::t_in_beat)-1:0];
        b.action = act;
        return b;
    endfunction

    // Cipher word near the interesting edge of the ciphered range half of
    // the time, with random lengths and indexes the rest.
    function automatic rkc_pkg::t_in_beat cipher_beat();
        rkc_pkg::t_in_beat b;
        b = random_beat(rkc_pkg::ACT_CIPHER);
        case ($urandom_range(3))
            0: ;
            1: b.packet_bytes = 16'($urandom_range(0, 2048));
            default: begin
                b.packet_bytes = 16'($urandom_range(0, 1100));
                b.word_index = 14'(int'(b.packet_bytes >> 2) + int'($urandom_range(0, 3)) - 2);
            end
        endcase
        return b;
    endfunction

    // Wait until every expected result is in and the block has settled.
    task automatic wait_idle();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_key_length(input logic [8:0] value);
        cfg_valid <= 1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    // Load every byte the schedule will use, so it never reads an unwritten
    // entry, then write the key length and run the schedule.
    task automatic rekey(input logic [8:0] key_len);
        rkc_pkg::t_in_beat b;
        int used;
        used = (key_len == 9'd0) ? 1
             : (key_len > rkc_pkg::KEY_MAX_BYTES) ? rkc_pkg::KEY_MAX_BYTES : int'(key_len);
        for (int i = 0; i < used; i++) begin
            b = random_beat(rkc_pkg::ACT_LOAD_KEY);
            b.key_index = i[7:0];
            if ($urandom_range(9) == 0) b.key_byte = ($urandom_range(1)) ? 8'hff : 8'h00;
            send_beat(b);
        end
        wait_idle();
        write_key_length(key_len);
        send_beat(random_beat(rkc_pkg::ACT_SCHEDULE));
    endtask

    task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
        rkc_pkg::t_in_beat b;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(19))
                0: begin
                    b = random_beat(rkc_pkg::ACT_LOAD_KEY);
                    send_beat(b);
                end
                1: send_beat(random_beat(rkc_pkg::ACT_UNUSED));
                default: send_beat(cipher_beat());
            endcase
        end
    endtask

    initial begin
        rkc_pkg::t_in_beat b;
        logic [8:0] lengths [6];
        rst_n = 0; in_valid = 0; in_data = '0;
        cfg_valid = 0; cfg_data = 9'd1;
        send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: schedule with reset key length, then the range edges.
        rekey(9'd1);
        for (int pb = 0; pb < 9; pb++) begin
            b = random_beat(rkc_pkg::ACT_CIPHER);
            b.packet_bytes = pb[15:0];
            b.word_index = (pb == 8) ? 14'd1 : 14'd0;
            send_beat(b);
        end
        b = random_beat(rkc_pkg::ACT_CIPHER);
        b.packet_bytes = 16'hffff; b.word_index = 14'h3ffe; b.data_word = '1;
        b.packet_number = '1;
        send_beat(b);
        b.packet_bytes = 16'hfffc; b.word_index = 14'h3fff; b.data_word = '0;
        b.packet_number = '0;
        send_beat(b);
        b.word_index = 14'd0;
        send_beat(b);
        send_beat(random_beat(rkc_pkg::ACT_UNUSED));
        wait_idle();

        // Key lengths, zero and beyond the store among them.
        lengths = '{9'd0, 9'd256, 9'd511, 9'd5, 9'd257, 9'd16};
        foreach (lengths[k]) begin
            wait_idle();
            rekey(lengths[k]);
            case (k % 4)
                0: run_phase(PHASE_BEATS, 0, 0);
                1: run_phase(PHASE_BEATS, 82, 0);
                2: run_phase(PHASE_BEATS, 0, 82);
                default: run_phase(PHASE_BEATS, 16, 16);
            endcase
            if (k == 1) begin
                // Hold the receiver off so the block backs up its input.
                hold_cycles = 200;
                run_phase(20, 0, 0);
            end
            if (k == 2) begin
                // The sender pauses until all results are in.
                wait_idle();
                run_phase(20, 0, 0);
            end
        end

        recv_stall_pct = 0;
        wait_idle();
        if (fail_count == 0) begin
            $display("rc4_keyed_table_packet_cipher_unit_test: PASS");
        end else begin
            $display("rc4_keyed_table_packet_cipher_unit_test: FAIL");
        end
        $finish;
    end
endmodule
